// ===== design/rgbshp_pkg.sv =====
// Shared types, constants and helpers for the RGB 3x3 sharpening filter.
`timescale 1ns / 1ps
`default_nettype none

package rgbshp_pkg;

    // Longest line the two line stores can hold.
    localparam int MAX_LINE_WIDTH = 1024;
    localparam int CHAN_BITS      = 8;
    localparam int PIX_BITS       = 3 * CHAN_BITS;
    localparam int COL_BITS       = $clog2(MAX_LINE_WIDTH);
    // Wide enough to hold the line width itself and the lag limit of width plus one.
    localparam int WID_BITS       = COL_BITS + 1;
    localparam int ROW_BITS       = 12;
    localparam int AW_CFG_BITS    = 11;
    localparam int AH_CFG_BITS    = 12;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 12;
    localparam int CMP_BITS       = 16;
    localparam int TAPS           = 9;
    localparam int CENTER_TAP     = 4;
    localparam int ACC_BITS       = CHAN_BITS + 5;

    localparam logic [AW_CFG_BITS-1:0] WIDTH_RESET  = AW_CFG_BITS'(640);
    localparam logic [AH_CFG_BITS-1:0] HEIGHT_RESET = AH_CFG_BITS'(480);
    localparam int MIN_SIZE = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_HEIGHT = 1'b1;

    // Request type codes.
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [CHAN_BITS-1:0] in_red;
        logic [CHAN_BITS-1:0] in_green;
        logic [CHAN_BITS-1:0] in_blue;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] out_red;
        logic [CHAN_BITS-1:0] out_green;
        logic [CHAN_BITS-1:0] out_blue;
        logic                 frame_end;
    } out_item_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } pixel_t;

    // Per-item decisions made by the counter logic at transfer time.
    typedef struct packed {
        logic is_pixel;
        logic has_result;
        logic compute;
        logic frame_end;
    } item_ctl_t;

    typedef logic [TAPS-1:0][CHAN_BITS-1:0] taps_t;

endpackage

`default_nettype wire

// ===== design/rgbshp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rgbshp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/rgbshp_ctrl.sv =====
// Configuration registers and raster counters that decide each item's result.
`timescale 1ns / 1ps
`default_nettype none

module rgbshp_ctrl (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               accept,
    input  wire logic                               req_type,
    input  wire logic                               cfg_wr_en,
    input  wire logic [rgbshp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [rgbshp_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output logic      [rgbshp_pkg::COL_BITS-1:0]    rd_addr,
    output rgbshp_pkg::item_ctl_t                   item_ctl
);

    import rgbshp_pkg::*;

    logic [AW_CFG_BITS-1:0] width_reg, width_next;
    logic [AH_CFG_BITS-1:0] height_reg, height_next;
    logic [COL_BITS-1:0]    in_col_reg, in_col_next;
    logic [ROW_BITS-1:0]    in_row_reg, in_row_next;
    logic [COL_BITS-1:0]    out_col_reg, out_col_next;
    logic [ROW_BITS-1:0]    out_row_reg, out_row_next;
    logic [WID_BITS-1:0]    lag_reg, lag_next;

    logic [CMP_BITS-1:0] aw_ext;
    logic [CMP_BITS-1:0] ew_ext;
    logic [WID_BITS-1:0] eff_w;
    logic [ROW_BITS-1:0] eff_h;
    logic [WID_BITS-1:0] in_col_inc;
    logic [ROW_BITS:0]   in_row_inc;
    logic [WID_BITS-1:0] out_col_inc;
    logic [ROW_BITS:0]   out_row_inc;
    logic [WID_BITS:0]   lag_limit;
    logic                is_pixel;
    logic                has_result;
    logic                border;
    logic                last_col;
    logic                last_row;

    // Effective frame size: width clamped to 3..max line, height at least 3.
    always_comb
    begin
        aw_ext = CMP_BITS'(width_reg);
        if (aw_ext < CMP_BITS'(MIN_SIZE))
        begin
            ew_ext = CMP_BITS'(MIN_SIZE);
        end
        else if (aw_ext > CMP_BITS'(MAX_LINE_WIDTH))
        begin
            ew_ext = CMP_BITS'(MAX_LINE_WIDTH);
        end
        else
        begin
            ew_ext = aw_ext;
        end
        eff_w = ew_ext[WID_BITS-1:0];
        if (height_reg < ROW_BITS'(MIN_SIZE))
        begin
            eff_h = ROW_BITS'(MIN_SIZE);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    always_comb
    begin
        is_pixel    = (req_type == REQ_PIXEL);
        in_col_inc  = WID_BITS'(in_col_reg) + 1'b1;
        in_row_inc  = (ROW_BITS+1)'(in_row_reg) + 1'b1;
        out_col_inc = WID_BITS'(out_col_reg) + 1'b1;
        out_row_inc = (ROW_BITS+1)'(out_row_reg) + 1'b1;
        lag_limit   = (WID_BITS+1)'(eff_w) + 1'b1;

        if (is_pixel)
        begin
            has_result = ((WID_BITS+1)'(lag_reg) >= lag_limit);
        end
        else
        begin
            has_result = (lag_reg != '0);
        end

        last_col = (WID_BITS'(out_col_reg) >= eff_w - 1'b1);
        last_row = (out_row_reg >= eff_h - 1'b1);
        border   = (out_row_reg == '0) || last_row || (out_col_reg == '0) || last_col;

        item_ctl.is_pixel   = is_pixel;
        item_ctl.has_result = has_result;
        item_ctl.compute    = is_pixel && has_result && !border;
        item_ctl.frame_end  = (out_row_reg == eff_h - 1'b1) &&
                              (WID_BITS'(out_col_reg) == eff_w - 1'b1);
        rd_addr = in_col_reg;
    end

    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lag_next     = lag_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ACTIVE_WIDTH:  width_next  = cfg_data[AW_CFG_BITS-1:0];
                CFG_ACTIVE_HEIGHT: height_next = cfg_data[AH_CFG_BITS-1:0];
                default:           ;
            endcase
        end

        if (accept)
        begin
            if (is_pixel)
            begin
                if (in_col_inc >= eff_w)
                begin
                    in_col_next = '0;
                    if (in_row_inc >= (ROW_BITS+1)'(eff_h))
                    begin
                        in_row_next = '0;
                    end
                    else
                    begin
                        in_row_next = in_row_inc[ROW_BITS-1:0];
                    end
                end
                else
                begin
                    in_col_next = in_col_inc[COL_BITS-1:0];
                end
                if (!has_result)
                begin
                    lag_next = lag_reg + 1'b1;
                end
            end
            else if (has_result)
            begin
                lag_next = lag_reg - 1'b1;
            end

            if (has_result)
            begin
                if (out_col_inc >= eff_w)
                begin
                    out_col_next = '0;
                    if (out_row_inc >= (ROW_BITS+1)'(eff_h))
                    begin
                        out_row_next = '0;
                    end
                    else
                    begin
                        out_row_next = out_row_inc[ROW_BITS-1:0];
                    end
                end
                else
                begin
                    out_col_next = out_col_inc[COL_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lag_reg     <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            lag_reg     <= lag_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/rgbshp_lane.sv =====
// One color channel of the sharpening kernel: 10*center minus the ring, halved and clamped.
`timescale 1ns / 1ps
`default_nettype none

module rgbshp_lane (
    input  rgbshp_pkg::taps_t                   taps,
    output logic [rgbshp_pkg::CHAN_BITS-1:0]    result
);

    import rgbshp_pkg::*;

    logic [ACC_BITS-1:0]        ten_center;
    logic [ACC_BITS-1:0]        ring_sum;
    logic signed [ACC_BITS-1:0] acc;
    logic [ACC_BITS-2:0]        half;

    always_comb
    begin
        ring_sum = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            if (k != CENTER_TAP)
            begin
                ring_sum = ring_sum + ACC_BITS'(taps[k]);
            end
        end
        ten_center = (ACC_BITS'(taps[CENTER_TAP]) << 3) + (ACC_BITS'(taps[CENTER_TAP]) << 1);
        acc  = signed'(ten_center - ring_sum);
        half = acc[ACC_BITS-1:1];

        // A non-positive sum floors to zero; otherwise halve and saturate.
        if (acc[ACC_BITS-1] || (acc == '0))
        begin
            result = '0;
        end
        else if (half > (ACC_BITS-1)'({CHAN_BITS{1'b1}}))
        begin
            result = '1;
        end
        else
        begin
            result = half[CHAN_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== design/rgb_sharpen_3x3_filter.sv =====
// Top level of the RGB 3x3 sharpening filter: line stores, window, lanes and output stage.
//
//   Channel | Signals                          | Transfer when
//   --------+----------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data      | in_valid && !in_stall
//   output  | out_valid, out_stall, out_data   | out_valid && !out_stall
//   config  | cfg_wr_en, cfg_index, cfg_data   | cfg_wr_en
//
// One item per clock is sustained while the output is not stalled; a result goes through
// line store read, window update and lane compute, then is held in the output register.
// The line stores are single-port-write RAMs read once per item, which sets that rate.
// Reset clears the counters, the window and the pipeline valid flags; the line stores
// are not cleared. A stalled output holds its result; input stalls once both stages fill behind it.
`timescale 1ns / 1ps
`default_nettype none

module rgb_sharpen_3x3_filter (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  rgbshp_pkg::in_item_t                      in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output rgbshp_pkg::out_item_t                     out_data,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [rgbshp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [rgbshp_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    import rgbshp_pkg::*;

    logic                accept;
    logic [COL_BITS-1:0] rd_addr;
    item_ctl_t           front_ctl;

    // Stage one: line store data arrives.
    logic                s1_valid_reg, s1_valid_next;
    item_ctl_t           s1_ctl_reg;
    pixel_t              s1_pix_reg;
    logic [COL_BITS-1:0] s1_addr_reg;

    // Stage two: window holds the item's neighborhood.
    logic                s2_valid_reg, s2_valid_next;
    item_ctl_t           s2_ctl_reg;
    pixel_t              win_reg [TAPS];
    pixel_t              win_next [TAPS];

    // Output register.
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg;

    logic   s1_go, s1_free, s2_go, s2_free, out_free;
    logic   load_out, write_lines;
    pixel_t top_pix, mid_pix;
    taps_t  red_taps, green_taps, blue_taps;
    logic [CHAN_BITS-1:0] red_res, green_res, blue_res;

    assign accept = in_valid && !in_stall;

    rgbshp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (in_data.req_type),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_addr   (rd_addr),
        .item_ctl  (front_ctl)
    );

    // Older line store sees the newer line's old value as each pixel passes.
    rgbshp_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_LINE_WIDTH)) u_older_line (
        .clk     (clk),
        .wr_en   (write_lines),
        .wr_addr (s1_addr_reg),
        .wr_data (mid_pix),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (top_pix)
    );

    rgbshp_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_LINE_WIDTH)) u_newer_line (
        .clk     (clk),
        .wr_en   (write_lines),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (mid_pix)
    );

    // Items without a result pass stage two without waiting on the output.
    always_comb
    begin
        out_free    = !out_valid_reg || !out_stall;
        s2_go       = s2_valid_reg && (!s2_ctl_reg.has_result || out_free);
        s2_free     = !s2_valid_reg || s2_go;
        s1_go       = s1_valid_reg && s2_free;
        s1_free     = !s1_valid_reg || s1_go;
        in_stall    = !s1_free;
        write_lines = s1_go && s1_ctl_reg.is_pixel;
        load_out    = s2_go && s2_ctl_reg.has_result;
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_go)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_go)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Window shifts one column left; the new column is older, newer and incoming pixel.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = top_pix;
        win_next[5] = mid_pix;
        win_next[8] = s1_pix_reg;
    end

    always_comb
    begin
        for (int k = 0; k < TAPS; k++)
        begin
            red_taps[k]   = win_reg[k].red;
            green_taps[k] = win_reg[k].green;
            blue_taps[k]  = win_reg[k].blue;
        end
    end

    rgbshp_lane u_lane_red   (.taps(red_taps),   .result(red_res));
    rgbshp_lane u_lane_green (.taps(green_taps), .result(green_res));
    rgbshp_lane u_lane_blue  (.taps(blue_taps),  .result(blue_res));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < TAPS; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (write_lines)
            begin
                for (int k = 0; k < TAPS; k++)
                begin
                    win_reg[k] <= win_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg  <= front_ctl;
            s1_pix_reg  <= '{red: in_data.in_red, green: in_data.in_green,
                             blue: in_data.in_blue};
            s1_addr_reg <= rd_addr;
        end
        if (s1_go)
        begin
            s2_ctl_reg <= s1_ctl_reg;
        end
        if (load_out)
        begin
            // Merge the three lanes; border pixels and flushed items come out as zero.
            out_data_reg.out_red   <= s2_ctl_reg.compute ? red_res   : '0;
            out_data_reg.out_green <= s2_ctl_reg.compute ? green_res : '0;
            out_data_reg.out_blue  <= s2_ctl_reg.compute ? blue_res  : '0;
            out_data_reg.frame_end <= s2_ctl_reg.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the RGB 3x3 sharpening filter: random and hand-built frames.
`timescale 1ns / 1ps

module tb_top;
    import rgbshp_pkg::*;

    localparam int RESET_WIDTH     = 640;
    localparam int RESET_HEIGHT    = 480;
    localparam int SETTLE_CYCLES   = 10;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_ITEMS    = 1400;

    typedef enum int {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;

    typedef struct packed {
        logic [31:0] col;
        logic [31:0] row;
    } raster_pos_t;

    // Tracks the filter's state on every input transfer and holds the results it must produce.
    class sharpen_scoreboard;
        logic [AW_CFG_BITS-1:0] width_reg;
        logic [AH_CFG_BITS-1:0] height_reg;
        logic [PIX_BITS-1:0]    older_line[MAX_LINE_WIDTH];
        logic [PIX_BITS-1:0]    newer_line[MAX_LINE_WIDTH];
        logic [PIX_BITS-1:0]    window[TAPS];
        raster_pos_t            in_pos;
        raster_pos_t            out_pos;
        int unsigned            in_flight;
        out_item_t              sharpened_due[$];
        int unsigned            pixels;
        int unsigned            flushes;
        int unsigned            results;
        int unsigned            errors;

        function new();
            width_reg = AW_CFG_BITS'(RESET_WIDTH);
            height_reg = AH_CFG_BITS'(RESET_HEIGHT);
            for (int i = 0; i < MAX_LINE_WIDTH; i++)
            begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            for (int k = 0; k < TAPS; k++)
                window[k] = '0;
            in_pos = '0;
            out_pos = '0;
            in_flight = 0;
            pixels = 0;
            flushes = 0;
            results = 0;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            if (idx == CFG_ACTIVE_WIDTH)
                width_reg = val[AW_CFG_BITS-1:0];
            else
                height_reg = val[AH_CFG_BITS-1:0];
        endfunction

        function int unsigned line_width();
            if (width_reg < MIN_SIZE)
                return MIN_SIZE;
            if (width_reg > MAX_LINE_WIDTH)
                return MAX_LINE_WIDTH;
            return width_reg;
        endfunction

        function int unsigned frame_height();
            return (height_reg < MIN_SIZE) ? MIN_SIZE : height_reg;
        endfunction

        function raster_pos_t next_pos(raster_pos_t p);
            raster_pos_t n;
            n = p;
            n.col = p.col + 1;
            if (n.col >= line_width())
            begin
                n.col = 0;
                n.row = (p.row + 1 >= frame_height()) ? 0 : p.row + 1;
            end
            return n;
        endfunction

        function logic [CHAN_BITS-1:0] sharpen_lane(int shift);
            int acc;
            int v;
            acc = 0;
            for (int k = 0; k < TAPS; k++)
            begin
                v = window[k][shift +: CHAN_BITS];
                if (k == CENTER_TAP)
                    acc += 10 * v;
                else
                    acc -= v;
            end
            if (acc <= 0)
                return '0;
            acc = acc / 2;
            return (acc > 255) ? 8'd255 : CHAN_BITS'(acc);
        endfunction

        function void take_input(in_item_t it);
            int unsigned w;
            int unsigned h;
            int unsigned ic;
            logic [PIX_BITS-1:0] px;
            logic computed;
            logic border;
            out_item_t res;
            w = line_width();
            h = frame_height();
            if (it.req_type == REQ_PIXEL)
            begin
                pixels++;
                px = {it.in_red, it.in_green, it.in_blue};
                ic = (in_pos.col >= MAX_LINE_WIDTH) ? 0 : in_pos.col;
                // Slide the window left; the new column is two stored lines over this pixel.
                for (int r = 0; r < 3; r++)
                begin
                    window[r * 3]     = window[r * 3 + 1];
                    window[r * 3 + 1] = window[r * 3 + 2];
                end
                window[2] = older_line[ic];
                window[5] = newer_line[ic];
                window[8] = px;
                older_line[ic] = newer_line[ic];
                newer_line[ic] = px;
                in_pos = next_pos(in_pos);
                if (in_flight < w + 1)
                begin
                    in_flight++;
                    return;
                end
                computed = 1'b1;
            end
            else
            begin
                flushes++;
                if (in_flight == 0)
                    return;
                in_flight--;
                computed = 1'b0;
            end
            border = out_pos.row == 0 || out_pos.row >= h - 1 ||
                     out_pos.col == 0 || out_pos.col >= w - 1;
            res = '0;
            if (computed && !border)
            begin
                res.out_red   = sharpen_lane(2 * CHAN_BITS);
                res.out_green = sharpen_lane(CHAN_BITS);
                res.out_blue  = sharpen_lane(0);
            end
            res.frame_end = (out_pos.row == h - 1) && (out_pos.col == w - 1);
            out_pos = next_pos(out_pos);
            sharpened_due.push_back(res);
        endfunction

        function void check_output(out_item_t got);
            out_item_t want;
            if (sharpened_due.size() == 0)
            begin
                $error("result %h arrived with nothing pending", got);
                errors++;
                return;
            end
            want = sharpened_due.pop_front();
            results++;
            if (got.out_red !== want.out_red)
            begin
                $error("out_red expected %0d actual %0d", want.out_red, got.out_red);
                errors++;
            end
            if (got.out_green !== want.out_green)
            begin
                $error("out_green expected %0d actual %0d", want.out_green, got.out_green);
                errors++;
            end
            if (got.out_blue !== want.out_blue)
            begin
                $error("out_blue expected %0d actual %0d", want.out_blue, got.out_blue);
                errors++;
            end
            if (got.frame_end !== want.frame_end)
            begin
                $error("frame_end expected %0d actual %0d", want.frame_end, got.frame_end);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    in_item_t                 in_data = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    out_item_t                out_data;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    pace_t pace = PACE_RX_SLOW;
    int    hold_left = 0;
    bit    held_once = 1'b0;
    int    frames_sent = 0;
    int    settings_used = 0;

    sharpen_scoreboard sb = new();

    rgb_sharpen_3x3_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int gap_pct(pace_t p, bit rx_side);
        case (p)
            PACE_RX_SLOW: return rx_side ? 52 : 18;
            PACE_TX_SLOW: return rx_side ? 18 : 52;
            default:      return 0;
        endcase
    endfunction

    function automatic in_item_t flush_item();
        in_item_t it;
        it = in_item_t'($urandom);
        it.req_type = REQ_FLUSH;
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < gap_pct(pace, 1'b0))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_input(it);
        @(negedge clk);
    endtask

    task automatic stream_pixels(input int count, input int flush_pct);
        in_item_t it;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < flush_pct)
                send_item(flush_item());
            it = in_item_t'($urandom);
            it.req_type = REQ_PIXEL;
            send_item(it);
        end
    endtask

    // Flush out every pixel still in flight, then wait for the last result to leave.
    task automatic drain_and_settle();
        while (sb.in_flight != 0)
            send_item(flush_item());
        in_valid <= 1'b0;
        while (sb.sharpened_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_geometry(input logic [CFG_DATA_BITS-1:0] w,
                                input logic [CFG_DATA_BITS-1:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ACTIVE_WIDTH;
        cfg_data <= w;
        sb.set_register(CFG_ACTIVE_WIDTH, w);
        @(negedge clk);
        cfg_index <= CFG_ACTIVE_HEIGHT;
        cfg_data <= h;
        sb.set_register(CFG_ACTIVE_HEIGHT, h);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    // Small random frames, now and then with sizes below the minimum.
    task automatic random_frames(input int budget);
        int spent;
        int frames;
        int w;
        int h;
        int pixel_count;
        spent = 0;
        while (spent < budget)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(24, 3);
            h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
            set_geometry(CFG_DATA_BITS'(w), CFG_DATA_BITS'(h));
            frames = $urandom_range(3, 1);
            pixel_count = frames * sb.line_width() * sb.frame_height();
            stream_pixels(pixel_count, 2);
            frames_sent += frames;
            spent += pixel_count;
            drain_and_settle();
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!held_once && pace == PACE_FULL && out_valid)
        begin
            // Hold the output long enough for the filter to back up into its input.
            held_once <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < gap_pct(pace, 1'b1));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_output(out_data);
    end

    initial
    begin
        in_item_t it;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Power-on geometry: three full lines give interior results on row one.
        stream_pixels(3 * RESET_WIDTH, 0);
        drain_and_settle();

        // Shrink to 3 x 3 while the counters sit on row three of the old frame.
        set_geometry(CFG_DATA_BITS'(MIN_SIZE), CFG_DATA_BITS'(MIN_SIZE));
        send_item(flush_item());
        stream_pixels(MIN_SIZE, 0);
        // Red saturates high, green goes negative, blue lands mid-range.
        for (int k = 0; k < TAPS; k++)
        begin
            it.req_type = REQ_PIXEL;
            it.in_red   = (k == CENTER_TAP) ? 8'd255 : 8'd0;
            it.in_green = (k == CENTER_TAP) ? 8'd0 : 8'd255;
            it.in_blue  = (k == CENTER_TAP) ? 8'd128 : 8'd129;
            send_item(it);
        end
        send_item(flush_item());
        // Flat white, an odd neighbor sum that rounds down, and a sum of exactly zero.
        for (int k = 0; k < TAPS; k++)
        begin
            it.req_type = REQ_PIXEL;
            it.in_red   = 8'd255;
            if (k == CENTER_TAP)
                it.in_green = 8'd20;
            else if (k == TAPS - 1)
                it.in_green = 8'd9;
            else
                it.in_green = (k < CENTER_TAP) ? CHAN_BITS'(k + 1) : CHAN_BITS'(k);
            it.in_blue  = (k == CENTER_TAP) ? 8'd8 : 8'd10;
            send_item(it);
        end
        frames_sent += 2;
        drain_and_settle();

        random_frames(RANDOM_ITEMS / 3);

        pace <= PACE_TX_SLOW;
        // Tallest frame on the narrowest line; a width of one reads as three.
        set_geometry(CFG_DATA_BITS'(1), CFG_DATA_BITS'(4095));
        stream_pixels(MIN_SIZE * 4095, 1);
        frames_sent++;
        drain_and_settle();
        random_frames(RANDOM_ITEMS / 3);

        pace <= PACE_FULL;
        // All ones in the width register clip to the line store size; zero height reads as three.
        set_geometry('1, '0);
        stream_pixels(MAX_LINE_WIDTH * MIN_SIZE, 0);
        frames_sent++;
        drain_and_settle();
        random_frames(RANDOM_ITEMS / 3);

        $display("Run covered %0d pixel and %0d flush transfers in %0d frames, %0d geometries.",
                 sb.pixels, sb.flushes, frames_sent, settings_used + 1);
        $display("Checked %0d sharpened results, %0d mismatches.", sb.results, sb.errors);
        if (sb.errors == 0 && sb.sharpened_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Run did not finish in time.");
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rgbshp_pkg.sv
design/rgbshp_ram.sv
design/rgbshp_ctrl.sv
design/rgbshp_lane.sv
design/rgb_sharpen_3x3_filter.sv
tb/tb_top.sv
